/* sv/swsfr_pkg.sv */
`timescale 1ns / 1ps

package swsfr_pkg;

    localparam int WINDOW_DEPTH_DEF = 8;
    localparam int DATA_WIDTH_DEF   = 64;

    localparam int SEQ_W     = 32;
    localparam int LIMIT_W   = 4;
    localparam int FLIGHT_W  = 4;
    localparam int DUP_W     = 3;
    localparam int OP_W      = 2;
    localparam int KIND_W    = 2;
    localparam int TIMER_W   = 2;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd4;
    localparam logic [SEQ_W-1:0]   SEQ_RESET   = 32'd1;
    localparam logic [DUP_W-1:0]   DUP_LIMIT   = 3'd4;
    localparam logic [DUP_W-1:0]   DUP_FIRST   = 3'd1;

    localparam logic [OP_W-1:0] OP_SEND    = 2'd0;
    localparam logic [OP_W-1:0] OP_ACK     = 2'd1;
    localparam logic [OP_W-1:0] OP_TIMEOUT = 2'd2;

    localparam logic [KIND_W-1:0] KIND_NONE    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_NEW     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RETX    = 2'd2;
    localparam logic [KIND_W-1:0] KIND_REFUSED = 2'd3;

    localparam logic [TIMER_W-1:0] TIMER_NONE       = 2'd0;
    localparam logic [TIMER_W-1:0] TIMER_START      = 2'd1;
    localparam logic [TIMER_W-1:0] TIMER_STOP       = 2'd2;
    localparam logic [TIMER_W-1:0] TIMER_STOP_START = 2'd3;

    typedef enum logic [1:0] {
        CMD_NONE    = 2'd0,
        CMD_SEND    = 2'd1,
        CMD_ACK     = 2'd2,
        CMD_TIMEOUT = 2'd3
    } cmd_cls_t;

    typedef struct packed {
        cmd_cls_t         cls;
        logic [SEQ_W-1:0] ack;
    } cmd_t;

endpackage

/* sv/swsfr_front.sv */
`timescale 1ns / 1ps

module swsfr_front #(
    parameter int DATA_WIDTH = swsfr_pkg::DATA_WIDTH_DEF
) (
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [swsfr_pkg::OP_W-1:0]    operation,
    input  logic [DATA_WIDTH-1:0]         payload_word,
    input  logic [swsfr_pkg::SEQ_W-1:0]   ack_number,
    input  logic                          ack_checksum_ok,
    input  logic                          q_full,
    output logic                          q_push,
    output swsfr_pkg::cmd_t               q_cmd,
    output logic [DATA_WIDTH-1:0]         q_data
);

    // Acks that failed the checksum and the unused operation code become no-ops here,
    // so the back end leaves the window unchanged for them, though they still pass through the queue.
    always_comb
    begin
        q_cmd.ack = ack_number;
        q_data    = payload_word;
        unique case (operation)
            swsfr_pkg::OP_SEND:
            begin
                q_cmd.cls = swsfr_pkg::CMD_SEND;
            end
            swsfr_pkg::OP_ACK:
            begin
                q_cmd.cls = ack_checksum_ok ? swsfr_pkg::CMD_ACK : swsfr_pkg::CMD_NONE;
            end
            swsfr_pkg::OP_TIMEOUT:
            begin
                q_cmd.cls = swsfr_pkg::CMD_TIMEOUT;
            end
            default:
            begin
                q_cmd.cls = swsfr_pkg::CMD_NONE;
            end
        endcase
    end

    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

endmodule

/* sv/swsfr_queue.sv */
`timescale 1ns / 1ps

module swsfr_queue #(
    parameter int WIDTH = $bits(swsfr_pkg::cmd_t) + swsfr_pkg::DATA_WIDTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PTR_W = $clog2(swsfr_pkg::QUEUE_DEPTH);
    localparam int CNT_W = PTR_W + 1;

    logic [WIDTH-1:0] entry_reg [swsfr_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full      = (count_reg == CNT_W'(swsfr_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* sv/swsfr_back.sv */
`timescale 1ns / 1ps

module swsfr_back #(
    parameter int WINDOW_DEPTH = swsfr_pkg::WINDOW_DEPTH_DEF,
    parameter int DATA_WIDTH   = swsfr_pkg::DATA_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            q_not_empty,
    input  swsfr_pkg::cmd_t                 q_cmd,
    input  logic [DATA_WIDTH-1:0]           q_data,
    output logic                            q_pop,
    input  logic                            cfg_we,
    input  logic [swsfr_pkg::LIMIT_W-1:0]   cfg_limit,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [swsfr_pkg::KIND_W-1:0]    packet_kind,
    output logic [swsfr_pkg::SEQ_W-1:0]     packet_seq,
    output logic [DATA_WIDTH-1:0]           packet_data,
    output logic [swsfr_pkg::TIMER_W-1:0]   timer_action,
    output logic [swsfr_pkg::SEQ_W-1:0]     timer_seq,
    output logic                            window_full
);

    localparam int SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int SUM_W  = SLOT_W + 5;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic                            state_reg;
    logic [swsfr_pkg::LIMIT_W-1:0]   limit_reg;
    logic [swsfr_pkg::SEQ_W-1:0]     base_reg;
    logic [swsfr_pkg::SEQ_W-1:0]     base_next;
    logic [swsfr_pkg::SEQ_W-1:0]     nseq_reg;
    logic [swsfr_pkg::SEQ_W-1:0]     nseq_next;
    logic [swsfr_pkg::FLIGHT_W-1:0]  flight_reg;
    logic [swsfr_pkg::FLIGHT_W-1:0]  flight_next;
    logic [swsfr_pkg::DUP_W-1:0]     dup_reg;
    logic [swsfr_pkg::DUP_W-1:0]     dup_next;
    logic [SLOT_W-1:0]               oldest_reg;
    logic [SLOT_W-1:0]               oldest_next;

    logic [DATA_WIDTH-1:0]           slot_mem [WINDOW_DEPTH];
    logic [DATA_WIDTH-1:0]           rd_data_reg;

    logic [swsfr_pkg::KIND_W-1:0]    pend_kind_reg;
    logic [swsfr_pkg::KIND_W-1:0]    pend_kind_next;
    logic [swsfr_pkg::SEQ_W-1:0]     pend_seq_reg;
    logic [swsfr_pkg::SEQ_W-1:0]     pend_seq_next;
    logic [swsfr_pkg::TIMER_W-1:0]   pend_tact_reg;
    logic [swsfr_pkg::TIMER_W-1:0]   pend_tact_next;
    logic [swsfr_pkg::SEQ_W-1:0]     pend_tseq_reg;
    logic [swsfr_pkg::SEQ_W-1:0]     pend_tseq_next;
    logic                            pend_full_reg;
    logic                            pend_full_next;
    logic                            pend_mem_reg;
    logic                            pend_mem_next;
    logic [DATA_WIDTH-1:0]           pend_data_reg;
    logic [DATA_WIDTH-1:0]           pend_data_next;

    logic                            out_valid_reg;
    logic [swsfr_pkg::KIND_W-1:0]    out_kind_reg;
    logic [swsfr_pkg::SEQ_W-1:0]     out_seq_reg;
    logic [DATA_WIDTH-1:0]           out_data_reg;
    logic [swsfr_pkg::TIMER_W-1:0]   out_tact_reg;
    logic [swsfr_pkg::SEQ_W-1:0]     out_tseq_reg;
    logic                            out_full_reg;

    logic [swsfr_pkg::LIMIT_W-1:0]   eff_limit;
    logic [swsfr_pkg::SEQ_W-1:0]     ack_span;
    logic [swsfr_pkg::DUP_W-1:0]     dup_inc;
    logic                            ack_ok;
    logic                            mem_we;
    logic [SLOT_W-1:0]               wr_slot;
    logic                            emit;

    function automatic logic [SLOT_W-1:0] ring_slot(
        input logic [SLOT_W-1:0]              start,
        input logic [swsfr_pkg::FLIGHT_W-1:0] offset
    );
        logic [SUM_W-1:0] sum;
        begin
            sum = SUM_W'(start) + SUM_W'(offset);
            if (sum >= SUM_W'(WINDOW_DEPTH))
            begin
                sum = sum - SUM_W'(WINDOW_DEPTH);
            end
            return sum[SLOT_W-1:0];
        end
    endfunction

    assign q_pop = (state_reg == ST_IDLE) && q_not_empty;
    assign emit  = (state_reg == ST_EMIT) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        if (32'(limit_reg) > 32'(WINDOW_DEPTH))
        begin
            eff_limit = swsfr_pkg::LIMIT_W'(WINDOW_DEPTH);
        end
        else
        begin
            eff_limit = limit_reg;
        end
    end

    assign ack_span = q_cmd.ack - base_reg;
    assign dup_inc  = dup_reg + 1'b1;
    assign ack_ok   = (flight_reg != '0)
        && (ack_span <= swsfr_pkg::SEQ_W'(flight_reg));
    assign wr_slot  = ring_slot(oldest_reg, flight_reg);

    // The oldest outstanding slot always holds sequence base_reg, so only payloads are stored.
    always_comb
    begin
        base_next      = base_reg;
        nseq_next      = nseq_reg;
        flight_next    = flight_reg;
        dup_next       = dup_reg;
        oldest_next    = oldest_reg;
        mem_we         = 1'b0;
        pend_kind_next = swsfr_pkg::KIND_NONE;
        pend_seq_next  = '0;
        pend_tact_next = swsfr_pkg::TIMER_NONE;
        pend_tseq_next = '0;
        pend_mem_next  = 1'b0;
        pend_data_next = '0;
        unique case (q_cmd.cls)
            swsfr_pkg::CMD_SEND:
            begin
                if (flight_reg < eff_limit)
                begin
                    mem_we         = 1'b1;
                    pend_kind_next = swsfr_pkg::KIND_NEW;
                    pend_seq_next  = nseq_reg;
                    pend_data_next = q_data;
                    if (flight_reg == '0)
                    begin
                        pend_tact_next = swsfr_pkg::TIMER_START;
                        pend_tseq_next = nseq_reg;
                    end
                    flight_next = flight_reg + 1'b1;
                    nseq_next   = nseq_reg + 1'b1;
                end
                else
                begin
                    pend_kind_next = swsfr_pkg::KIND_REFUSED;
                end
            end
            swsfr_pkg::CMD_ACK:
            begin
                if (ack_ok)
                begin
                    if (ack_span == '0)
                    begin
                        if (dup_inc >= swsfr_pkg::DUP_LIMIT)
                        begin
                            pend_kind_next = swsfr_pkg::KIND_RETX;
                            pend_seq_next  = base_reg;
                            pend_mem_next  = 1'b1;
                            pend_tact_next = swsfr_pkg::TIMER_STOP_START;
                            pend_tseq_next = base_reg;
                            dup_next       = '0;
                        end
                        else
                        begin
                            dup_next = dup_inc;
                            if (dup_inc == swsfr_pkg::DUP_FIRST)
                            begin
                                pend_tact_next = swsfr_pkg::TIMER_STOP_START;
                                pend_tseq_next = base_reg;
                            end
                        end
                    end
                    else
                    begin
                        dup_next    = swsfr_pkg::DUP_FIRST;
                        base_next   = q_cmd.ack;
                        oldest_next = ring_slot(oldest_reg, ack_span[swsfr_pkg::FLIGHT_W-1:0]);
                        flight_next = flight_reg - ack_span[swsfr_pkg::FLIGHT_W-1:0];
                        if (q_cmd.ack == nseq_reg)
                        begin
                            pend_tact_next = swsfr_pkg::TIMER_STOP;
                            pend_tseq_next = base_reg;
                        end
                        else
                        begin
                            pend_tact_next = swsfr_pkg::TIMER_STOP_START;
                            pend_tseq_next = q_cmd.ack;
                        end
                    end
                end
            end
            swsfr_pkg::CMD_TIMEOUT:
            begin
                if (flight_reg != '0)
                begin
                    pend_kind_next = swsfr_pkg::KIND_RETX;
                    pend_seq_next  = base_reg;
                    pend_mem_next  = 1'b1;
                    pend_tact_next = swsfr_pkg::TIMER_STOP_START;
                    pend_tseq_next = base_reg;
                end
            end
            default:
            begin
                pend_kind_next = swsfr_pkg::KIND_NONE;
            end
        endcase
        pend_full_next = (flight_next >= eff_limit);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            limit_reg     <= swsfr_pkg::LIMIT_RESET;
            base_reg      <= swsfr_pkg::SEQ_RESET;
            nseq_reg      <= swsfr_pkg::SEQ_RESET;
            flight_reg    <= '0;
            dup_reg       <= '0;
            oldest_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                limit_reg <= cfg_limit;
            end
            if (q_pop)
            begin
                state_reg  <= ST_EMIT;
                base_reg   <= base_next;
                nseq_reg   <= nseq_next;
                flight_reg <= flight_next;
                dup_reg    <= dup_next;
                oldest_reg <= oldest_next;
            end
            else if (emit)
            begin
                state_reg <= ST_IDLE;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            rd_data_reg   <= slot_mem[oldest_reg];
            pend_kind_reg <= pend_kind_next;
            pend_seq_reg  <= pend_seq_next;
            pend_tact_reg <= pend_tact_next;
            pend_tseq_reg <= pend_tseq_next;
            pend_full_reg <= pend_full_next;
            pend_mem_reg  <= pend_mem_next;
            pend_data_reg <= pend_data_next;
            if (mem_we)
            begin
                slot_mem[wr_slot] <= q_data;
            end
        end
        if (emit)
        begin
            out_kind_reg <= pend_kind_reg;
            out_seq_reg  <= pend_seq_reg;
            out_data_reg <= pend_mem_reg ? rd_data_reg : pend_data_reg;
            out_tact_reg <= pend_tact_reg;
            out_tseq_reg <= pend_tseq_reg;
            out_full_reg <= pend_full_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign packet_kind  = out_kind_reg;
    assign packet_seq   = out_seq_reg;
    assign packet_data  = out_data_reg;
    assign timer_action = out_tact_reg;
    assign timer_seq    = out_tseq_reg;
    assign window_full  = out_full_reg;

endmodule

/* sv/sliding_window_sender_fast_retransmit_core.sv */
`timescale 1ns / 1ps

// Channel   Direction  Handshake             Payload
// input     in         in_valid / in_stall   operation, payload_word, ack_number, ack_checksum_ok
// result    out        out_valid / out_stall packet_kind, packet_seq, packet_data, timer_action,
//                                            timer_seq, window_full
// config    in         cfg_valid / cfg_ready window_limit
//
// In the back end each transaction first updates the window state and reads the oldest slot
// from the payload memory, then assembles the result into the output register.
// A two-entry queue lets the input side keep taking transactions while a result is stalled.
// Reset is asynchronous and active low; the payload memory is not cleared.
// A result passes through the queue entry, the pending registers and the output register.

module sliding_window_sender_fast_retransmit_core #(
    parameter int WINDOW_DEPTH = swsfr_pkg::WINDOW_DEPTH_DEF,
    parameter int DATA_WIDTH   = swsfr_pkg::DATA_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [swsfr_pkg::OP_W-1:0]      operation,
    input  logic [DATA_WIDTH-1:0]           payload_word,
    input  logic [swsfr_pkg::SEQ_W-1:0]     ack_number,
    input  logic                            ack_checksum_ok,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [swsfr_pkg::KIND_W-1:0]    packet_kind,
    output logic [swsfr_pkg::SEQ_W-1:0]     packet_seq,
    output logic [DATA_WIDTH-1:0]           packet_data,
    output logic [swsfr_pkg::TIMER_W-1:0]   timer_action,
    output logic [swsfr_pkg::SEQ_W-1:0]     timer_seq,
    output logic                            window_full,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [swsfr_pkg::LIMIT_W-1:0]   window_limit
);

    localparam int CMD_W   = $bits(swsfr_pkg::cmd_t);
    localparam int ENTRY_W = CMD_W + DATA_WIDTH;

    logic                  q_push;
    logic                  q_full;
    logic                  q_pop;
    logic                  q_not_empty;
    swsfr_pkg::cmd_t       front_cmd;
    logic [DATA_WIDTH-1:0] front_data;
    logic [ENTRY_W-1:0]    q_out;
    swsfr_pkg::cmd_t       back_cmd;
    logic [DATA_WIDTH-1:0] back_data;

    swsfr_front #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_front (
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .operation       (operation),
        .payload_word    (payload_word),
        .ack_number      (ack_number),
        .ack_checksum_ok (ack_checksum_ok),
        .q_full          (q_full),
        .q_push          (q_push),
        .q_cmd           (front_cmd),
        .q_data          (front_data)
    );

    swsfr_queue #(
        .WIDTH (ENTRY_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data ({front_cmd, front_data}),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (q_out)
    );

    assign back_cmd  = swsfr_pkg::cmd_t'(q_out[ENTRY_W-1:DATA_WIDTH]);
    assign back_data = q_out[DATA_WIDTH-1:0];
    assign cfg_ready = 1'b1;

    swsfr_back #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .DATA_WIDTH   (DATA_WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_not_empty  (q_not_empty),
        .q_cmd        (back_cmd),
        .q_data       (back_data),
        .q_pop        (q_pop),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_limit    (window_limit),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .packet_kind  (packet_kind),
        .packet_seq   (packet_seq),
        .packet_data  (packet_data),
        .timer_action (timer_action),
        .timer_seq    (timer_seq),
        .window_full  (window_full)
    );

endmodule

/* sv/swsfr_checker.sv */
`timescale 1ns / 1ps

module swsfr_checker #(
    parameter int DATA_WIDTH = swsfr_pkg::DATA_WIDTH_DEF
) (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            out_valid,
    input logic                            out_stall,
    input logic [swsfr_pkg::KIND_W-1:0]    packet_kind,
    input logic [swsfr_pkg::SEQ_W-1:0]     packet_seq,
    input logic [DATA_WIDTH-1:0]           packet_data,
    input logic [swsfr_pkg::TIMER_W-1:0]   timer_action,
    input logic [swsfr_pkg::SEQ_W-1:0]     timer_seq,
    input logic                            window_full
);

    // A stalled result transaction stays valid with its kind, sequence, data and timer action unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(packet_kind)
            && $stable(packet_seq) && $stable(packet_data) && $stable(timer_action))
        else $error("result changed while stalled");

    // A retransmission always restarts the timer on the packet it resends.
    a_retx_timer: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && packet_kind == swsfr_pkg::KIND_RETX
            |-> timer_action == swsfr_pkg::TIMER_STOP_START && timer_seq == packet_seq)
        else $error("retransmission without matching timer restart");

    // A new packet either leaves the timer alone or starts it on itself.
    a_new_timer: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && packet_kind == swsfr_pkg::KIND_NEW
            |-> timer_action == swsfr_pkg::TIMER_NONE
                || (timer_action == swsfr_pkg::TIMER_START && timer_seq == packet_seq))
        else $error("new packet with wrong timer command");

    // A refused send only happens against a full window, and carries no packet.
    a_refused: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && packet_kind == swsfr_pkg::KIND_REFUSED
            |-> window_full && packet_seq == '0 && packet_data == '0)
        else $error("refused send with open window or stray payload");

    // Without a timer command the timer sequence field reads zero.
    a_timer_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && timer_action == swsfr_pkg::TIMER_NONE |-> timer_seq == '0)
        else $error("timer sequence set without timer command");

endmodule

bind sliding_window_sender_fast_retransmit_core swsfr_checker #(
    .DATA_WIDTH (DATA_WIDTH)
) u_swsfr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .packet_kind  (packet_kind),
    .packet_seq   (packet_seq),
    .packet_data  (packet_data),
    .timer_action (timer_action),
    .timer_seq    (timer_seq),
    .window_full  (window_full)
);

/* sim/swsfr_window_checker.sv */
`timescale 1ns / 1ps

module swsfr_window_checker
    import swsfr_pkg::*;
#(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
    parameter int DATA_WIDTH   = DATA_WIDTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  logic [OP_W-1:0]       operation,
    input  logic [DATA_WIDTH-1:0] payload_word,
    input  logic [SEQ_W-1:0]      ack_number,
    input  logic                  ack_checksum_ok,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  logic [KIND_W-1:0]     packet_kind,
    input  logic [SEQ_W-1:0]      packet_seq,
    input  logic [DATA_WIDTH-1:0] packet_data,
    input  logic [TIMER_W-1:0]    timer_action,
    input  logic [SEQ_W-1:0]      timer_seq,
    input  logic                  window_full,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [LIMIT_W-1:0]    window_limit,
    output int                    errors,
    output int                    pending,
    output logic [SEQ_W-1:0]      window_base,
    output logic [FLIGHT_W-1:0]   window_count
);

    typedef struct packed {
        logic [KIND_W-1:0]     kind;
        logic [SEQ_W-1:0]      seq;
        logic [DATA_WIDTH-1:0] data;
        logic [TIMER_W-1:0]    tact;
        logic [SEQ_W-1:0]      tseq;
        logic                  full;
    } packet_t;

    logic [LIMIT_W-1:0]    limit_reg;
    logic [SEQ_W-1:0]      base_seq;
    logic [SEQ_W-1:0]      next_seq;
    logic [FLIGHT_W-1:0]   in_flight;
    logic [DUP_W-1:0]      dup_count;
    int                    oldest_slot;
    logic [SEQ_W-1:0]      slot_seq [WINDOW_DEPTH];
    logic [DATA_WIDTH-1:0] slot_data [WINDOW_DEPTH];
    packet_t               packet_due [$];

    assign window_base  = base_seq;
    assign window_count = in_flight;

    function automatic int usable_window();
        if (int'(limit_reg) > WINDOW_DEPTH)
        begin
            return WINDOW_DEPTH;
        end
        return int'(limit_reg);
    endfunction

    function automatic void resend_oldest(ref packet_t p);
        p.kind = KIND_RETX;
        p.seq  = slot_seq[oldest_slot];
        p.data = slot_data[oldest_slot];
        p.tact = TIMER_STOP_START;
        p.tseq = slot_seq[oldest_slot];
    endfunction

    task automatic step_window(input logic [OP_W-1:0] op, input logic [DATA_WIDTH-1:0] data,
                               input logic [SEQ_W-1:0] ack, input logic ck,
                               output packet_t p);
        int              idx;
        logic [SEQ_W-1:0] ack_span;
        logic            slide;
        p = '0;
        case (op)
            OP_SEND:
            begin
                if (int'(in_flight) < usable_window())
                begin
                    idx = (oldest_slot + int'(in_flight)) % WINDOW_DEPTH;
                    slot_seq[idx]  = next_seq;
                    slot_data[idx] = data;
                    p.kind = KIND_NEW;
                    p.seq  = next_seq;
                    p.data = data;
                    if (in_flight == 0)
                    begin
                        p.tact = TIMER_START;
                        p.tseq = next_seq;
                    end
                    in_flight = in_flight + 1'b1;
                    next_seq  = next_seq + 1'b1;
                end
                else
                begin
                    p.kind = KIND_REFUSED;
                end
            end
            OP_ACK:
            begin
                ack_span = ack - base_seq;
                if (in_flight != 0 && ck && ack_span <= SEQ_W'(in_flight))
                begin
                    slide = 1'b1;
                    if (ack == slot_seq[oldest_slot])
                    begin
                        dup_count = dup_count + 1'b1;
                        if (dup_count >= DUP_LIMIT)
                        begin
                            resend_oldest(p);
                            dup_count = '0;
                            slide = 1'b0;
                        end
                        else if (dup_count != DUP_FIRST)
                        begin
                            slide = 1'b0;
                        end
                    end
                    else
                    begin
                        dup_count = DUP_FIRST;
                    end
                    if (slide)
                    begin
                        idx = (oldest_slot + int'(ack_span)) % WINDOW_DEPTH;
                        base_seq = ack;
                        if (base_seq == next_seq)
                        begin
                            p.tact = TIMER_STOP;
                            p.tseq = slot_seq[oldest_slot];
                        end
                        else
                        begin
                            p.tact = TIMER_STOP_START;
                            p.tseq = slot_seq[idx];
                        end
                        oldest_slot = idx;
                        in_flight = in_flight - ack_span[FLIGHT_W-1:0];
                    end
                end
            end
            OP_TIMEOUT:
            begin
                if (in_flight != 0)
                begin
                    resend_oldest(p);
                end
            end
            default:
            begin
            end
        endcase
        p.full = (int'(in_flight) >= usable_window());
    endtask

    task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : check_proc
        packet_t want;
        if (!rst_n)
        begin
            limit_reg   = LIMIT_RESET;
            base_seq    = SEQ_RESET;
            next_seq    = SEQ_RESET;
            in_flight   = '0;
            dup_count   = '0;
            oldest_slot = 0;
            for (int i = 0; i < WINDOW_DEPTH; i++)
            begin
                slot_seq[i]  = '0;
                slot_data[i] = '0;
            end
            packet_due.delete();
            pending = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (packet_due.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result transaction, expected none, actual kind %0h",
                             $time, packet_kind);
                end
                else
                begin
                    want = packet_due.pop_front();
                    check_field("packet_kind", want.kind, packet_kind);
                    check_field("packet_seq", want.seq, packet_seq);
                    check_field("packet_data", want.data, packet_data);
                    check_field("timer_action", want.tact, timer_action);
                    check_field("timer_seq", want.tseq, timer_seq);
                    check_field("window_full", want.full, window_full);
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                limit_reg = window_limit;
            end
            if (in_valid && !in_stall)
            begin
                step_window(operation, payload_word, ack_number, ack_checksum_ok, want);
                packet_due.push_back(want);
            end
            pending = packet_due.size();
        end
    end

endmodule

/* sim/tb_sliding_window_sender_fast_retransmit_core.sv */
`timescale 1ns / 1ps

module tb_sliding_window_sender_fast_retransmit_core;

    import swsfr_pkg::*;

    localparam int DEPTH = WINDOW_DEPTH_DEF;
    localparam int DW    = DATA_WIDTH_DEF;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [OP_W-1:0]     operation;
    logic [DW-1:0]       payload_word;
    logic [SEQ_W-1:0]    ack_number;
    logic                ack_checksum_ok;
    logic                out_valid;
    logic                out_stall;
    logic [KIND_W-1:0]   packet_kind;
    logic [SEQ_W-1:0]    packet_seq;
    logic [DW-1:0]       packet_data;
    logic [TIMER_W-1:0]  timer_action;
    logic [SEQ_W-1:0]    timer_seq;
    logic                window_full;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [LIMIT_W-1:0]  window_limit;

    int                  errors;
    int                  pending;
    logic [SEQ_W-1:0]    window_base;
    logic [FLIGHT_W-1:0] window_count;

    int gap_pct;
    int stall_pct;
    int stall_left;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    sliding_window_sender_fast_retransmit_core #(
        .WINDOW_DEPTH (DEPTH),
        .DATA_WIDTH   (DW)
    ) u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .operation       (operation),
        .payload_word    (payload_word),
        .ack_number      (ack_number),
        .ack_checksum_ok (ack_checksum_ok),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .packet_kind     (packet_kind),
        .packet_seq      (packet_seq),
        .packet_data     (packet_data),
        .timer_action    (timer_action),
        .timer_seq       (timer_seq),
        .window_full     (window_full),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .window_limit    (window_limit)
    );

    swsfr_window_checker #(
        .WINDOW_DEPTH (DEPTH),
        .DATA_WIDTH   (DW)
    ) u_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .operation       (operation),
        .payload_word    (payload_word),
        .ack_number      (ack_number),
        .ack_checksum_ok (ack_checksum_ok),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .packet_kind     (packet_kind),
        .packet_seq      (packet_seq),
        .packet_data     (packet_data),
        .timer_action    (timer_action),
        .timer_seq       (timer_seq),
        .window_full     (window_full),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .window_limit    (window_limit),
        .errors          (errors),
        .pending         (pending),
        .window_base     (window_base),
        .window_count    (window_count)
    );

    function automatic int pick_gap();
        if ($urandom_range(99) < 88)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(12, 40);
    endfunction

    initial
    begin : result_stall
        out_stall  = 1'b0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
            end
            else if (stall_pct > 0 && $urandom_range(99) < stall_pct)
            begin
                out_stall <= 1'b1;
                stall_left = pick_gap() - 1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    task automatic idle_input(input int cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    task automatic drive_item(input logic [OP_W-1:0] op, input logic [DW-1:0] data,
                              input logic [SEQ_W-1:0] ack, input logic ck);
        if (gap_pct > 0 && $urandom_range(99) < gap_pct)
        begin
            idle_input(pick_gap());
        end
        in_valid        <= 1'b1;
        operation       <= op;
        payload_word    <= data;
        ack_number      <= ack;
        ack_checksum_ok <= ck;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] value);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        cfg_valid    <= 1'b1;
        window_limit <= value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Most traffic follows the window: sends, in-range acks and duplicate runs.
    task automatic random_traffic(input int count);
        int               done;
        int               pick;
        int               burst;
        logic [DW-1:0]    data;
        logic [SEQ_W-1:0] ack;
        done = 0;
        while (done < count)
        begin
            pick = $urandom_range(99);
            data = {$urandom, $urandom};
            ack  = window_base + $urandom_range(window_count);
            if (pick < 40)
            begin
                case ($urandom_range(9))
                    0: data = '0;
                    1: data = '1;
                    default: ;
                endcase
                drive_item(OP_SEND, data, $urandom, 1'($urandom_range(1)));
                done++;
            end
            else if (pick < 64)
            begin
                drive_item(OP_ACK, data, ack, 1'b1);
                done++;
            end
            else if (pick < 76)
            begin
                burst = $urandom_range(1, 5);
                repeat (burst) drive_item(OP_ACK, {$urandom, $urandom}, window_base, 1'b1);
                done += burst;
            end
            else if (pick < 85)
            begin
                drive_item(OP_TIMEOUT, data, $urandom, 1'($urandom_range(1)));
                done++;
            end
            else if (pick < 92)
            begin
                drive_item(OP_ACK, data, $urandom, 1'($urandom_range(1)));
                done++;
            end
            else if (pick < 96)
            begin
                drive_item(OP_ACK, data, ack, 1'b0);
                done++;
            end
            else
            begin
                drive_item(OP_UNUSED, data, $urandom, 1'($urandom_range(1)));
                done++;
            end
        end
    endtask

    initial
    begin : stimulus
        int phase_limit [10] = '{1, 8, 3, 6, 2, 8, 5, 7, 4, 1};
        int phase_gap   [10] = '{0, 20, 40, 10, 60, 0, 30, 15, 50, 25};
        int phase_stall [10] = '{0, 30, 10, 50, 20, 60, 0, 40, 15, 35};
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        operation       = OP_SEND;
        payload_word    = '0;
        ack_number      = '0;
        ack_checksum_ok = 1'b0;
        cfg_valid       = 1'b0;
        window_limit    = LIMIT_RESET;
        gap_pct         = 25;
        stall_pct       = 25;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        drive_item(OP_TIMEOUT, '0, '0, 1'b0);
        drive_item(OP_ACK, '0, SEQ_RESET, 1'b1);
        drive_item(OP_UNUSED, '1, '1, 1'b1);
        drive_item(OP_SEND, '0, '1, 1'b0);
        drive_item(OP_SEND, '1, '0, 1'b1);
        drive_item(OP_SEND, 64'hA5A5_A5A5_A5A5_A5A5, '0, 1'b1);
        drive_item(OP_SEND, 64'h5A5A_5A5A_5A5A_5A5A, '0, 1'b0);
        drive_item(OP_SEND, 64'h0123_4567_89AB_CDEF, '0, 1'b1);
        drive_item(OP_ACK, '0, 32'd2, 1'b0);
        drive_item(OP_ACK, '0, 32'd0, 1'b1);
        drive_item(OP_ACK, '0, 32'hFFFF_FFFF, 1'b1);
        drive_item(OP_ACK, '0, 32'd6, 1'b1);
        repeat (4) drive_item(OP_ACK, '0, 32'd1, 1'b1);
        drive_item(OP_TIMEOUT, '0, '0, 1'b0);
        drive_item(OP_ACK, '0, 32'd3, 1'b1);
        drive_item(OP_ACK, '0, 32'd5, 1'b1);
        drive_item(OP_SEND, 64'hDEAD_BEEF_CAFE_F00D, '0, 1'b1);
        drive_item(OP_ACK, '0, 32'd6, 1'b1);

        for (int ph = 0; ph < 10; ph++)
        begin
            write_limit(LIMIT_W'(phase_limit[ph]));
            gap_pct   = phase_gap[ph];
            stall_pct = phase_stall[ph];
            random_traffic(175);
        end

        in_valid <= 1'b0;
        gap_pct   = 0;
        stall_pct = 0;
        while (pending != 0) @(negedge clk);
        repeat (10) @(negedge clk);
        if (errors == 0)
        begin
            $display("tb_sliding_window_sender_fast_retransmit_core: clean");
        end
        else
        begin
            $display("tb_sliding_window_sender_fast_retransmit_core: errors");
        end
        $finish;
    end

    initial
    begin : watchdog
        #10_000_000;
        $display("tb_sliding_window_sender_fast_retransmit_core: errors");
        $finish;
    end

endmodule
